/* rtl/goertzel_tone_trigger_defines.svh */
// Assertion helpers for the tone trigger block
`ifndef GOERTZEL_TONE_TRIGGER_DEFINES_SVH
`define GOERTZEL_TONE_TRIGGER_DEFINES_SVH

// checked only outside reset
`define GTT_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked during reset as well
`define GTT_CHECK_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/gtt_pkg.sv */
`default_nettype none
package gtt_pkg;
   localparam int RES_BITS           = 48;
   localparam int ENERGY_BITS        = 48;
   localparam int LEN_BITS           = 13;
   localparam int RATIO_BITS         = 13;
   localparam int CSR_ADDR_BITS      = 2;
   localparam int CSR_DATA_BITS      = 32;
   localparam int MUL_BITS           = 112;
   localparam int MB_BITS            = 64;
   localparam int OUT_BITS           = 16;
   localparam int DEF_SAMPLE_BITS    = 16;
   localparam int DEF_MAX_WINDOW     = 4096;
   localparam int DEF_COEF_FRAC_BITS = 16;

   localparam logic [LEN_BITS-1:0]   WLEN_RESET  = 13'd1024;
   localparam logic [RATIO_BITS-1:0] RATIO_RESET = 13'd511;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      REG_COEF  = 2'd0,
      REG_WLEN  = 2'd1,
      REG_RATIO = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic signed [RES_BITS-1:0] p;
      logic signed [RES_BITS-1:0] q;
      logic [ENERGY_BITS-1:0]     energy;
   } window_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;
endpackage
`default_nettype wire

/* rtl/gtt_queue.sv */
`default_nettype none
module gtt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  gtt_pkg::window_type push_data,
   input  logic                pop,
   output gtt_pkg::window_type pop_data,
   output gtt_pkg::qstat_type  qstat
);
   import gtt_pkg::*;

   window_type mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   assign qstat.full  = (cnt_ff == 2'd2);
   assign qstat.empty = (cnt_ff == 2'd0);
   assign pop_data    = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         if (push && !pop) cnt_ff <= cnt_ff + 2'd1;
         else if (pop && !push) cnt_ff <= cnt_ff - 2'd1;
      end
   end
endmodule
`default_nettype wire

/* rtl/gtt_front.sv */
`default_nettype none
module gtt_front #(
   parameter int SAMPLE_BITS    = gtt_pkg::DEF_SAMPLE_BITS,
   parameter int COEF_FRAC_BITS = gtt_pkg::DEF_COEF_FRAC_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample,
   input  logic signed [COEF_FRAC_BITS+1:0]      coef,
   input  logic [gtt_pkg::LEN_BITS-1:0]          win_n,
   input  gtt_pkg::qstat_type                    qstat,
   output logic                                  q_push,
   output gtt_pkg::window_type                   q_data
);
   import gtt_pkg::*;

   localparam int CW       = COEF_FRAC_BITS + 2;
   localparam int LOW_BITS = RES_BITS / 2;
   localparam int PW       = CW + RES_BITS + 1;
   localparam int TW       = PW - COEF_FRAC_BITS;
   localparam int SW       = TW + 2;
   localparam int LOW_PW   = CW + LOW_BITS + 1;
   localparam int HI_PW    = CW + RES_BITS - LOW_BITS;
   localparam logic signed [SW-1:0] SMAX = SW'({(RES_BITS-1){1'b1}});
   localparam logic signed [SW-1:0] SMIN = ~SMAX;

   typedef enum logic [1:0] {F_IDLE, F_HI, F_UPD} fstate_type;

   fstate_type                           state_ff;
   logic signed [SAMPLE_BITS-1:0]        x_ff;
   logic signed [2*SAMPLE_BITS-1:0]      xx_ff;
   logic signed [CW+LOW_BITS:0]          lo_ff;
   logic signed [CW+RES_BITS-LOW_BITS-1:0] hi_ff;
   logic signed [RES_BITS-1:0]           prev_ff, prev2_ff;
   logic [ENERGY_BITS-1:0]               energy_ff;
   logic [LEN_BITS-1:0]                  cnt_ff;

   logic signed [PW-1:0]        full_c, rnd_c, shr_c;
   logic signed [TW-1:0]        t_c;
   logic signed [SW-1:0]        s0w_c;
   logic signed [RES_BITS-1:0]  s0_c;
   logic [ENERGY_BITS:0]        esum_c;
   logic [ENERGY_BITS-1:0]      e_c;
   logic [LEN_BITS-1:0]         cnt_in;
   logic                        end_c;

   always_comb begin
      full_c = (PW'(hi_ff) <<< LOW_BITS) + PW'(lo_ff);
      rnd_c  = full_c + (PW'(1) <<< (COEF_FRAC_BITS - 1));
      shr_c  = rnd_c >>> COEF_FRAC_BITS;
      t_c    = $signed(shr_c[TW-1:0]);
      s0w_c  = SW'(x_ff) + SW'(t_c) - SW'(prev2_ff);
      if (s0w_c > SMAX) s0_c = {1'b0, {(RES_BITS-1){1'b1}}};
      else if (s0w_c < SMIN) s0_c = {1'b1, {(RES_BITS-1){1'b0}}};
      else s0_c = s0w_c[RES_BITS-1:0];
      esum_c = (ENERGY_BITS+1)'(energy_ff) + (ENERGY_BITS+1)'($unsigned(xx_ff));
      e_c    = esum_c[ENERGY_BITS] ? '1 : esum_c[ENERGY_BITS-1:0];
      cnt_in = cnt_ff + 1'b1;
      end_c  = (cnt_in >= win_n);
   end

   assign req_stall     = (state_ff != F_IDLE);
   assign q_push        = (state_ff == F_UPD) && end_c && !qstat.full;
   assign q_data.p      = s0_c;
   assign q_data.q      = prev_ff;
   assign q_data.energy = e_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         prev_ff   <= '0;
         prev2_ff  <= '0;
         energy_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (req_valid) begin
                  x_ff     <= req_sample;
                  xx_ff    <= (2*SAMPLE_BITS)'(req_sample) * (2*SAMPLE_BITS)'(req_sample);
                  lo_ff    <= LOW_PW'(coef) *
                              LOW_PW'($signed({1'b0, prev_ff[LOW_BITS-1:0]}));
                  state_ff <= F_HI;
               end
            end
            F_HI: begin
               hi_ff    <= HI_PW'(coef) * HI_PW'($signed(prev_ff[RES_BITS-1:LOW_BITS]));
               state_ff <= F_UPD;
            end
            F_UPD: begin
               // hold the finished window until the queue has room
               if (!(end_c && qstat.full)) begin
                  if (end_c) begin
                     prev_ff   <= '0;
                     prev2_ff  <= '0;
                     energy_ff <= '0;
                     cnt_ff    <= '0;
                  end else begin
                     prev_ff   <= s0_c;
                     prev2_ff  <= prev_ff;
                     energy_ff <= e_c;
                     cnt_ff    <= cnt_in;
                  end
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

/* rtl/gtt_back.sv */
`default_nettype none
module gtt_back #(
   parameter int COEF_FRAC_BITS = gtt_pkg::DEF_COEF_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  gtt_pkg::qstat_type                  qstat,
   input  gtt_pkg::window_type                 q_data,
   output logic                                q_pop,
   input  logic signed [COEF_FRAC_BITS+1:0]    coef,
   input  logic [gtt_pkg::LEN_BITS-1:0]        win_n,
   input  logic [gtt_pkg::RATIO_BITS-1:0]      ratio,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [gtt_pkg::OUT_BITS-1:0]        rsp_tone_rms,
   output logic [gtt_pkg::OUT_BITS-1:0]        rsp_signal_rms,
   output logic                                rsp_triggered
);
   import gtt_pkg::*;

   localparam int CW = COEF_FRAC_BITS + 2;
   localparam int PW = CW + RES_BITS + 1;
   localparam int TW = PW - COEF_FRAC_BITS;

   typedef enum logic [3:0] {
      B_IDLE, B_T, B_PP, B_QQ, B_PT, B_MAG, B_RHS, B_LHS,
      B_SQT, B_DVT, B_DVS, B_SQS, B_OUT
   } bstate_type;

   bstate_type              state_ff;
   window_type              win_ff;
   logic [MUL_BITS-1:0]     ma_ff, acc_ff, sqs_ff, tm_ff, rhs_ff;
   logic [MB_BITS-1:0]      mb_ff;
   logic signed [TW-1:0]    t_ff;
   logic                    trig_ff, big_ff;
   logic [MB_BITS-1:0]      rad_ff, dnum_ff;
   logic [33:0]             rem_ff;
   logic [31:0]             root_ff;
   logic [LEN_BITS-1:0]     drem_ff;
   logic [5:0]              cnt_ff;
   logic [OUT_BITS-1:0]     tone_ff, sig_ff;
   logic                    rsp_valid_ff;
   logic [OUT_BITS-1:0]     rsp_tone_ff, rsp_sig_ff;
   logic                    rsp_trig_ff;

   function automatic logic [RES_BITS-1:0] mag48(input logic signed [RES_BITS-1:0] v);
      return v[RES_BITS-1] ? RES_BITS'(-v) : RES_BITS'(v);
   endfunction

   logic [CW-1:0]         cmag_c;
   logic [TW-1:0]         tmag_c;
   logic                  mul_done;
   logic [MUL_BITS-1:0]   acc_step;
   logic signed [PW-1:0]  prod_c, rnd_c, shr_c;
   logic [MUL_BITS-1:0]   mag_c;
   logic [33:0]           srem_n, strial;
   logic [33:0]           srem_nxt;
   logic [31:0]           sroot_nxt;
   logic [LEN_BITS:0]     drem_n;
   logic [LEN_BITS-1:0]   drem_nxt;
   logic [MB_BITS-1:0]    dnum_nxt;

   always_comb begin
      cmag_c   = coef[CW-1] ? CW'(-coef) : CW'(coef);
      tmag_c   = t_ff[TW-1] ? TW'(-t_ff) : TW'(t_ff);
      mul_done = (mb_ff == '0);
      acc_step = acc_ff + (mb_ff[0] ? ma_ff : '0);
      // signed coef*q, rounded to nearest
      prod_c = (coef[CW-1] ^ win_ff.q[RES_BITS-1]) ? -$signed(acc_ff[PW-1:0])
                                                   : $signed(acc_ff[PW-1:0]);
      rnd_c  = prod_c + (PW'(1) <<< (COEF_FRAC_BITS - 1));
      shr_c  = rnd_c >>> COEF_FRAC_BITS;
      // clamp a negative magnitude to zero
      if (win_ff.p[RES_BITS-1] != t_ff[TW-1]) mag_c = sqs_ff + acc_ff;
      else if (sqs_ff < acc_ff) mag_c = '0;
      else mag_c = sqs_ff - acc_ff;
      // one root digit per cycle
      srem_n = {rem_ff[31:0], rad_ff[MB_BITS-1:MB_BITS-2]};
      strial = {root_ff, 2'b01};
      if (srem_n >= strial) begin
         srem_nxt  = srem_n - strial;
         sroot_nxt = {root_ff[30:0], 1'b1};
      end else begin
         srem_nxt  = srem_n;
         sroot_nxt = {root_ff[30:0], 1'b0};
      end
      // one quotient bit per cycle
      drem_n = {drem_ff, dnum_ff[MB_BITS-1]};
      if (drem_n >= (LEN_BITS+1)'(win_n)) begin
         drem_nxt = LEN_BITS'(drem_n - (LEN_BITS+1)'(win_n));
         dnum_nxt = {dnum_ff[MB_BITS-2:0], 1'b1};
      end else begin
         drem_nxt = drem_n[LEN_BITS-1:0];
         dnum_nxt = {dnum_ff[MB_BITS-2:0], 1'b0};
      end
   end

   assign q_pop          = (state_ff == B_IDLE) && !qstat.empty;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tone_rms   = rsp_tone_ff;
   assign rsp_signal_rms = rsp_sig_ff;
   assign rsp_triggered  = rsp_trig_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != B_OUT) rsp_valid_ff <= 1'b0;
         if (!mul_done) begin
            acc_ff <= acc_step;
            ma_ff  <= ma_ff << 1;
            mb_ff  <= mb_ff >> 1;
         end
         unique case (state_ff)
            B_IDLE: begin
               if (!qstat.empty) begin
                  win_ff   <= q_data;
                  ma_ff    <= MUL_BITS'(cmag_c);
                  mb_ff    <= MB_BITS'(mag48(q_data.q));
                  acc_ff   <= '0;
                  state_ff <= B_T;
               end
            end
            B_T: begin
               if (mul_done) begin
                  t_ff     <= $signed(shr_c[TW-1:0]);
                  ma_ff    <= MUL_BITS'(mag48(win_ff.p));
                  mb_ff    <= MB_BITS'(mag48(win_ff.p));
                  acc_ff   <= '0;
                  state_ff <= B_PP;
               end
            end
            B_PP: begin
               if (mul_done) begin
                  sqs_ff   <= acc_ff;
                  ma_ff    <= MUL_BITS'(mag48(win_ff.q));
                  mb_ff    <= MB_BITS'(mag48(win_ff.q));
                  acc_ff   <= '0;
                  state_ff <= B_QQ;
               end
            end
            B_QQ: begin
               if (mul_done) begin
                  sqs_ff   <= sqs_ff + acc_ff;
                  ma_ff    <= MUL_BITS'(mag48(win_ff.p));
                  mb_ff    <= MB_BITS'(tmag_c);
                  acc_ff   <= '0;
                  state_ff <= B_PT;
               end
            end
            B_PT: begin
               if (mul_done) begin
                  tm_ff    <= mag_c << 1;
                  state_ff <= B_MAG;
               end
            end
            B_MAG: begin
               ma_ff    <= tm_ff;
               mb_ff    <= MB_BITS'(ratio);
               acc_ff   <= '0;
               state_ff <= B_RHS;
            end
            B_RHS: begin
               if (mul_done) begin
                  rhs_ff   <= acc_ff;
                  ma_ff    <= MUL_BITS'(win_ff.energy);
                  mb_ff    <= MB_BITS'({win_n, 8'd0});
                  acc_ff   <= '0;
                  state_ff <= B_LHS;
               end
            end
            B_LHS: begin
               if (mul_done) begin
                  trig_ff  <= (acc_ff < rhs_ff);
                  big_ff   <= |tm_ff[MUL_BITS-1:MB_BITS];
                  rad_ff   <= tm_ff[MB_BITS-1:0];
                  rem_ff   <= '0;
                  root_ff  <= '0;
                  cnt_ff   <= '0;
                  state_ff <= B_SQT;
               end
            end
            B_SQT: begin
               rad_ff  <= rad_ff << 2;
               rem_ff  <= srem_nxt;
               root_ff <= sroot_nxt;
               if (cnt_ff == 6'd31) begin
                  dnum_ff  <= MB_BITS'(sroot_nxt);
                  drem_ff  <= '0;
                  cnt_ff   <= '0;
                  state_ff <= B_DVT;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            B_DVT: begin
               if (cnt_ff == 6'd63) begin
                  tone_ff <= (big_ff || (dnum_nxt[MB_BITS-1:OUT_BITS] != '0))
                             ? '1 : dnum_nxt[OUT_BITS-1:0];
                  dnum_ff  <= MB_BITS'(win_ff.energy);
                  drem_ff  <= '0;
                  cnt_ff   <= '0;
                  state_ff <= B_DVS;
               end else begin
                  dnum_ff <= dnum_nxt;
                  drem_ff <= drem_nxt;
                  cnt_ff  <= cnt_ff + 1'b1;
               end
            end
            B_DVS: begin
               dnum_ff <= dnum_nxt;
               drem_ff <= drem_nxt;
               if (cnt_ff == 6'd63) begin
                  rad_ff   <= dnum_nxt;
                  rem_ff   <= '0;
                  root_ff  <= '0;
                  cnt_ff   <= '0;
                  state_ff <= B_SQS;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            B_SQS: begin
               rad_ff  <= rad_ff << 2;
               rem_ff  <= srem_nxt;
               root_ff <= sroot_nxt;
               cnt_ff  <= cnt_ff + 1'b1;
               if (cnt_ff == 6'd31) begin
                  sig_ff   <= (sroot_nxt[31:OUT_BITS] != '0) ? '1 : sroot_nxt[OUT_BITS-1:0];
                  state_ff <= B_OUT;
               end
            end
            B_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_tone_ff  <= tone_ff;
                  rsp_sig_ff   <= sig_ff;
                  rsp_trig_ff  <= trig_ff;
                  state_ff     <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

/* rtl/goertzel_tone_trigger.sv */
// Front end takes a new sample only when idle (split coefficient multiply, then update).
// Each window result is worked out in the back end by the shift-add multiplier, two 32-step
// square roots and two 64-step divides.
// A two-entry queue lets the front keep sampling while the back works on a finished window.
// Reset (synchronous, active high) clears the resonator, energy, count, queue and output
// valid, and loads coef 0, window length 1024 and ratio 511.
`default_nettype none
`include "goertzel_tone_trigger_defines.svh"
module goertzel_tone_trigger #(
   parameter int SAMPLE_BITS    = gtt_pkg::DEF_SAMPLE_BITS,
   parameter int MAX_WINDOW     = gtt_pkg::DEF_MAX_WINDOW,
   parameter int COEF_FRAC_BITS = gtt_pkg::DEF_COEF_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [gtt_pkg::OUT_BITS-1:0]        rsp_tone_rms,
   output logic [gtt_pkg::OUT_BITS-1:0]        rsp_signal_rms,
   output logic                                rsp_triggered,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gtt_pkg::CSR_ADDR_BITS-1:0]   csr_index,
   input  logic [gtt_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import gtt_pkg::*;

   localparam int CW = COEF_FRAC_BITS + 2;
   localparam logic [LEN_BITS-1:0] MAXW =
      (MAX_WINDOW > 8191) ? 13'd8191 : LEN_BITS'(MAX_WINDOW);

   logic signed [CW-1:0]     coef_ff;
   logic [LEN_BITS-1:0]      wlen_ff;
   logic [RATIO_BITS-1:0]    ratio_ff;
   logic [LEN_BITS-1:0]      win_n;
   logic                     q_push, q_pop;
   window_type               q_wdata, q_rdata;
   qstat_type                qstat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff  <= '0;
         wlen_ff  <= WLEN_RESET;
         ratio_ff <= RATIO_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_COEF:  coef_ff  <= csr_wdata[CW-1:0];
            REG_WLEN:  wlen_ff  <= csr_wdata[LEN_BITS-1:0];
            REG_RATIO: ratio_ff <= csr_wdata[RATIO_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (wlen_ff < 13'd2) win_n = 13'd2;
      else if (wlen_ff > MAXW) win_n = MAXW;
      else win_n = wlen_ff;
   end

   gtt_front #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_sample(req_sample),
      .coef(coef_ff), .win_n(win_n),
      .qstat(qstat), .q_push(q_push), .q_data(q_wdata)
   );

   gtt_queue u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .push_data(q_wdata),
      .pop(q_pop), .pop_data(q_rdata), .qstat(qstat)
   );

   gtt_back #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_back (
      .clock(clock), .reset(reset),
      .qstat(qstat), .q_data(q_rdata), .q_pop(q_pop),
      .coef(coef_ff), .win_n(win_n), .ratio(ratio_ff),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_tone_rms(rsp_tone_rms), .rsp_signal_rms(rsp_signal_rms),
      .rsp_triggered(rsp_triggered)
   );

   `GTT_CHECK(a_no_push_full, !(q_push && qstat.full), "window pushed into a full queue")
   `GTT_CHECK(a_no_pop_empty, !(q_pop && qstat.empty), "window popped from an empty queue")
   `GTT_CHECK(a_busy_after_req, req_valid && !req_stall |=> req_stall, "front took a second sample")
   `GTT_CHECK_RST(a_rsp_reset, reset |=> !rsp_valid, "result valid right after reset")
endmodule
`default_nettype wire
